@@ rtl/assert_macros.svh @@
// Assertion macros shared by the buddy block splitter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BBS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define BBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bbs_pkg.sv @@
// Types, codes and helpers shared by the buddy block splitter modules.
// No dependencies.
package bbs_pkg;

	localparam int ORDER_W = 3;
	localparam int REQ_W   = 7;
	localparam int ID_W    = 16;
	localparam int COUNT_W = 7;
	localparam int RKIND_W = 2;
	localparam int RDOP_W  = 2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [RKIND_W-1:0] RES_ALLOC_DONE  = 2'd0;
	localparam logic [RKIND_W-1:0] RES_NO_SPACE    = 2'd1;
	localparam logic [RKIND_W-1:0] RES_QUERY_ENTRY = 2'd2;

	localparam logic [RDOP_W-1:0] RD_SCAN  = 2'd0;
	localparam logic [RDOP_W-1:0] RD_SHIFT = 2'd1;
	localparam logic [RDOP_W-1:0] RD_QUERY = 2'd2;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   block_id;
		logic [REQ_W-1:0]  request_size;
	} bbs_in_t;

	typedef struct packed {
		logic [RKIND_W-1:0] result_kind;
		logic [COUNT_W-1:0] block_count;
		logic [ID_W-1:0]    entry_id;
		logic               last;
	} bbs_out_t;

	typedef struct packed {
		logic              init_list;
		logic              load;
		logic              rd;
		logic [RDOP_W-1:0] rd_op;
		logic              rd_down;
		logic              mark;
		logic              split_setup;
		logic              fill_wr;
		logic              respond;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_kind;
		logic ptr_at_end;
		logic ptr_at_split;
		logic exact_found;
		logic big_found;
		logic tail_empty;
		logic fill_last;
	} ctl_sts_t;

	// smallest order whose block holds req units, saturating at 7
	function automatic logic [ORDER_W-1:0] order_for(input logic [REQ_W-1:0] req);
		logic [ORDER_W-1:0] o;
		o = '0;
		for (int k = 0; k < (1 << ORDER_W) - 1; k++) begin
			if (REQ_W'(1 << k) < req)
				o = o + ORDER_W'(1);
		end
		return o;
	endfunction

endpackage

@@ rtl/bbs_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
module bbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bbs_ctrl.sv @@
// Sequencing state machine for the buddy block splitter.
// Depends on bbs_pkg for the command and status structs.
module bbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              start,
	input  bbs_pkg::ctl_sts_t sts,
	output bbs_pkg::ctl_cmd_t ctl,
	output logic              busy
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_SDRAIN  = 4'd3;
	localparam logic [3:0] S_DECIDE  = 4'd4;
	localparam logic [3:0] S_SHIFT   = 4'd5;
	localparam logic [3:0] S_SHDRAIN = 4'd6;
	localparam logic [3:0] S_FILL    = 4'd7;
	localparam logic [3:0] S_RESP    = 4'd8;
	localparam logic [3:0] S_QUERY   = 4'd9;
	localparam logic [3:0] S_QDRAIN  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE) || cfg_we;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = (sts.in_kind == bbs_pkg::KIND_QUERY) ? S_QUERY : S_SCAN;
				end
			end
			S_INIT: begin
				ctl.init_list = 1'b1;
				state_d       = S_IDLE;
			end
			S_SCAN: begin
				ctl.rd    = 1'b1;
				ctl.rd_op = bbs_pkg::RD_SCAN;
				if (sts.ptr_at_end)
					state_d = S_SDRAIN;
			end
			S_SDRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.exact_found) begin
					ctl.mark = 1'b1;
					state_d  = S_RESP;
				end else if (sts.big_found) begin
					ctl.split_setup = 1'b1;
					state_d         = sts.tail_empty ? S_FILL : S_SHIFT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				ctl.rd      = 1'b1;
				ctl.rd_op   = bbs_pkg::RD_SHIFT;
				ctl.rd_down = 1'b1;
				if (sts.ptr_at_split)
					state_d = S_SHDRAIN;
			end
			S_SHDRAIN: begin
				state_d = S_FILL;
			end
			S_FILL: begin
				ctl.fill_wr = 1'b1;
				if (sts.fill_last)
					state_d = S_RESP;
			end
			S_RESP: begin
				ctl.respond = 1'b1;
				state_d     = S_IDLE;
			end
			S_QUERY: begin
				ctl.rd    = 1'b1;
				ctl.rd_op = bbs_pkg::RD_QUERY;
				if (sts.ptr_at_end)
					state_d = S_QDRAIN;
			end
			S_QDRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_we)
			state_d = S_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_d;
	end

endmodule

@@ rtl/bbs_dpath.sv @@
// Datapath of the buddy block splitter: block list RAM, scan, shift and fill.
// Depends on bbs_pkg, bbs_ram and assert_macros.svh.
`include "assert_macros.svh"

module bbs_dpath #(
	parameter int MAX_ORDER = 6,
	parameter int ID_WIDTH  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bbs_pkg::ORDER_W-1:0]        cfg_data,
	input  bbs_pkg::bbs_in_t                   cmd_in,
	input  bbs_pkg::ctl_cmd_t                  ctl,
	output bbs_pkg::ctl_sts_t                  sts,
	output bbs_pkg::bbs_out_t                  result,
	output logic                               result_valid
);

	localparam int Depth = 1 << MAX_ORDER;
	localparam int AddrW = MAX_ORDER;
	localparam int CntW  = MAX_ORDER + 1;
	localparam int OwnW  = (ID_WIDTH < bbs_pkg::ID_W) ? ID_WIDTH : bbs_pkg::ID_W;
	localparam int OrdW  = bbs_pkg::ORDER_W;
	localparam int WordW = OrdW + 1 + OwnW;

	typedef struct packed {
		logic [OrdW-1:0] order;
		logic            used;
		logic [OwnW-1:0] owner;
	} word_t;

	logic [OrdW-1:0]           total_order_q;
	logic [OrdW-1:0]           tot_sat;
	logic [CntW-1:0]           len_q;
	logic [CntW-1:0]           len_m1;
	logic [CntW-1:0]           ptr_q;
	logic [OwnW-1:0]           id_q;
	logic [OrdW-1:0]           want_q;
	logic                      exact_found_q;
	logic [AddrW-1:0]          exact_idx_q;
	logic                      big_found_q;
	logic [AddrW-1:0]          big_idx_q;
	logic [OrdW-1:0]           big_order_q;
	logic [OrdW-1:0]           d_q;
	logic [OrdW-1:0]           fill_q;
	logic                      rd_valid_s1;
	logic [bbs_pkg::RDOP_W-1:0] rd_op_s1;
	logic [AddrW-1:0]          rd_idx_s1;
	logic                      ram_we;
	logic [AddrW-1:0]          ram_waddr;
	word_t                     ram_wword;
	logic [WordW-1:0]          ram_rdata;
	word_t                     rd_word;
	logic                      success;
	bbs_pkg::bbs_out_t         result_q;
	logic                      result_valid_q;

	assign tot_sat = (total_order_q > OrdW'(MAX_ORDER)) ? OrdW'(MAX_ORDER) : total_order_q;
	assign len_m1  = len_q - CntW'(1);
	assign rd_word = word_t'(ram_rdata);
	assign success = exact_found_q | big_found_q;

	assign sts.in_kind      = cmd_in.kind;
	assign sts.ptr_at_end   = (ptr_q == len_m1);
	assign sts.ptr_at_split = (ptr_q == CntW'(big_idx_q) + CntW'(1));
	assign sts.exact_found  = exact_found_q;
	assign sts.big_found    = big_found_q;
	assign sts.tail_empty   = (CntW'(big_idx_q) == len_m1);
	assign sts.fill_last    = (fill_q == d_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wword = '0;
		if (ctl.init_list) begin
			ram_we          = 1'b1;
			ram_wword.order = tot_sat;
		end else if (ctl.mark) begin
			ram_we    = 1'b1;
			ram_waddr = exact_idx_q;
			ram_wword = '{order: want_q, used: 1'b1, owner: id_q};
		end else if (ctl.fill_wr) begin
			ram_we    = 1'b1;
			ram_waddr = big_idx_q + AddrW'(fill_q);
			if (fill_q == '0)
				ram_wword = '{order: want_q, used: 1'b1, owner: id_q};
			else
				ram_wword.order = want_q + fill_q - OrdW'(1);
		end else if (rd_valid_s1 && (rd_op_s1 == bbs_pkg::RD_SHIFT)) begin
			ram_we    = 1'b1;
			ram_waddr = rd_idx_s1 + AddrW'(d_q);
			ram_wword = rd_word;
		end
	end

	bbs_ram #(
		.WIDTH(WordW),
		.DEPTH(Depth)
	) u_list (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(WordW'(ram_wword)),
		.raddr(ptr_q[AddrW-1:0]),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_order_q  <= OrdW'(6);
			len_q          <= CntW'(1);
			exact_found_q  <= 1'b0;
			big_found_q    <= 1'b0;
			rd_valid_s1    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				total_order_q <= cfg_data;
			if (ctl.init_list)
				len_q <= CntW'(1);
			if (ctl.fill_wr && (fill_q == d_q))
				len_q <= len_q + CntW'(d_q);
			if (ctl.load) begin
				exact_found_q <= 1'b0;
				big_found_q   <= 1'b0;
			end
			if (rd_valid_s1 && (rd_op_s1 == bbs_pkg::RD_SCAN) && !rd_word.used) begin
				if ((rd_word.order == want_q) && !exact_found_q)
					exact_found_q <= 1'b1;
				if ((rd_word.order > want_q) && !big_found_q)
					big_found_q <= 1'b1;
			end
			rd_valid_s1    <= ctl.rd;
			result_valid_q <= ctl.respond || (rd_valid_s1 && (rd_op_s1 == bbs_pkg::RD_QUERY));
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q   <= cmd_in.block_id[OwnW-1:0];
			want_q <= bbs_pkg::order_for(cmd_in.request_size);
			ptr_q  <= '0;
		end
		if (ctl.rd)
			ptr_q <= ctl.rd_down ? ptr_q - CntW'(1) : ptr_q + CntW'(1);
		if (ctl.split_setup) begin
			d_q    <= big_order_q - want_q;
			ptr_q  <= len_m1;
			fill_q <= '0;
		end
		if (ctl.fill_wr)
			fill_q <= fill_q + OrdW'(1);
		rd_op_s1  <= ctl.rd_op;
		rd_idx_s1 <= ptr_q[AddrW-1:0];
		if (rd_valid_s1 && (rd_op_s1 == bbs_pkg::RD_SCAN) && !rd_word.used) begin
			if ((rd_word.order == want_q) && !exact_found_q)
				exact_idx_q <= rd_idx_s1;
			if ((rd_word.order > want_q) && !big_found_q) begin
				big_idx_q   <= rd_idx_s1;
				big_order_q <= rd_word.order;
			end
		end
		if (ctl.respond) begin
			result_q.result_kind <= success ? bbs_pkg::RES_ALLOC_DONE : bbs_pkg::RES_NO_SPACE;
			result_q.block_count <= bbs_pkg::COUNT_W'(len_q);
			result_q.entry_id    <= success ? bbs_pkg::ID_W'(id_q) : '0;
			result_q.last        <= 1'b1;
		end else if (rd_valid_s1 && (rd_op_s1 == bbs_pkg::RD_QUERY)) begin
			result_q.result_kind <= bbs_pkg::RES_QUERY_ENTRY;
			result_q.block_count <= bbs_pkg::COUNT_W'(len_q);
			result_q.entry_id    <= rd_word.used ? bbs_pkg::ID_W'(rd_word.owner) : '0;
			result_q.last        <= (CntW'(rd_idx_s1) == len_m1);
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	`BBS_ASSERT(a_len_range, clk, arst_n, (len_q != '0) && (len_q <= CntW'(Depth)), "list length out of range")
	`BBS_ASSERT(a_fill_needs_split, clk, arst_n, ctl.fill_wr |-> big_found_q, "fill without a block to split")
	`BBS_ASSERT_NEXT(a_read_in_list, clk, arst_n, ctl.rd, rd_valid_s1 && (CntW'(rd_idx_s1) <= len_m1), "read beyond list end")

endmodule

@@ rtl/buddy_block_splitter_unit.sv @@
// Top level of the buddy block splitter: allocate-only buddy allocator.
// Depends on bbs_pkg, bbs_ctrl and bbs_dpath.
//
// channel   direction  handshake                     payload
// command   in         start, busy                   cmd    (bbs_in_t)
// result    out        result_valid (one cycle)      result (bbs_out_t)
// config    in         cfg_valid, cfg_ready          cfg_data (total_order)
//
// Allocate: scans the list, marks the first free exact fit, or else splits
//   the first larger free block, shifting the tail and filling in the buddies.
// Query: one result per block, in consecutive cycles.
// After reset and each config write, S_INIT rewrites the first list entry (busy high).
// Results are registered after their last work cycle; the receiver cannot stall.
module buddy_block_splitter_unit #(
	parameter int MAX_ORDER = 6,
	parameter int ID_WIDTH  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  bbs_pkg::bbs_in_t            cmd,
	output bbs_pkg::bbs_out_t           result,
	output logic                        result_valid,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bbs_pkg::ORDER_W-1:0] cfg_data
);

	logic              cfg_we;
	bbs_pkg::ctl_cmd_t ctl;
	bbs_pkg::ctl_sts_t sts;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	bbs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.start (start),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy)
	);

	bbs_dpath #(
		.MAX_ORDER(MAX_ORDER),
		.ID_WIDTH (ID_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.cmd_in      (cmd),
		.ctl         (ctl),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule
